// File: design/glob_path_or_name_matcher_top_defines.svh
// Assertion macros shared by the glob path or name matcher.
`ifndef GLOB_PATH_OR_NAME_MATCHER_TOP_DEFINES_SVH
`define GLOB_PATH_OR_NAME_MATCHER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GPM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GPM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/gpm_pkg.sv
// Package with the types, constants and functions of the glob path or name matcher.
package gpm_pkg;

    localparam int PATTERN_MAX = 16;
    localparam int POS_W       = PATTERN_MAX + 1;
    localparam int LEN_W       = $clog2(PATTERN_MAX + 1);
    localparam int PLEN_W      = 5;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 64;
    localparam int BYTE_W      = 8;

    localparam logic [BYTE_W-1:0] STAR_BYTE      = 8'h2A;
    localparam logic [BYTE_W-1:0] ANY_BYTE       = 8'h3F;
    localparam logic [BYTE_W-1:0] SLASH_BYTE     = 8'h2F;
    localparam logic [BYTE_W-1:0] BACKSLASH_BYTE = 8'h5C;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_HEAD   = 2'd0,
        REG_PATTERN_TAIL   = 2'd1,
        REG_PATTERN_LENGTH = 2'd2
    } t_reg_idx;

    typedef logic [POS_W-1:0]       t_pos;
    typedef logic [PATTERN_MAX-1:0] t_mask;
    typedef logic [BYTE_W-1:0]      t_byte;

    typedef struct packed {
        t_mask                        active;
        t_mask                        star;
        t_mask                        wild;
        t_byte [PATTERN_MAX-1:0]      bytes;
        t_pos                         start;
        logic [LEN_W-1:0]             len;
    } t_pat;

    // Position j is reached when some set position k at or before it is followed
    // only by star bytes up to j.
    function automatic t_pos close_stars(t_pos set, t_mask star);
        t_pos r;
        logic run;
        r = '0;
        for (int j = 0; j < POS_W; j++) begin
            for (int k = 0; k <= j; k++) begin
                run = set[k];
                for (int m = k; m < j; m++) begin
                    run = run & star[m];
                end
                r[j] = r[j] | run;
            end
        end
        return r;
    endfunction

endpackage

// File: design/gpm_if.sv
// Channel interfaces for configuration writes, path bytes and match results.
interface gpm_cfg_if;
    import gpm_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

interface gpm_item_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last_char;
    logic       empty_string;
    modport source (output valid, output char_code, output last_char, output empty_string,
                    input ready);
    modport sink (input valid, input char_code, input last_char, input empty_string,
                  output ready);
endinterface

interface gpm_result_if;
    logic valid;
    logic ready;
    logic path_match;
    logic name_match;
    logic any_match;
    modport source (output valid, output path_match, output name_match, output any_match,
                    input ready);
    modport sink (input valid, input path_match, input name_match, input any_match,
                  output ready);
endinterface

// File: design/gpm_cfg.sv
// Pattern registers and their decode into per-position match flags.
module gpm_cfg import gpm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    gpm_cfg_if.sink     i_cfg,
    output t_pat        o_pat
);

    logic [CFG_DATA_W-1:0]   r_head;
    logic [CFG_DATA_W-1:0]   r_tail;
    logic [PLEN_W-1:0]       r_len;
    logic [2*CFG_DATA_W-1:0] w_all;
    logic [LEN_W-1:0]        w_len;
    t_pat                    w_pat;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_len  <= '0;
        end else if (i_cfg.valid) begin
            unique case (t_reg_idx'(i_cfg.index))
                REG_PATTERN_HEAD:   r_head <= i_cfg.data;
                REG_PATTERN_TAIL:   r_tail <= i_cfg.data;
                REG_PATTERN_LENGTH: r_len  <= i_cfg.data[PLEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_all = {r_tail, r_head};
    assign w_len = (r_len > PLEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX) : LEN_W'(r_len);

    always_comb begin
        w_pat = '0;
        w_pat.len = w_len;
        for (int i = 0; i < PATTERN_MAX; i++) begin
            w_pat.bytes[i]  = w_all[BYTE_W*i +: BYTE_W];
            w_pat.active[i] = LEN_W'(i) < w_len;
            w_pat.star[i]   = w_pat.active[i] && (w_pat.bytes[i] == STAR_BYTE);
            w_pat.wild[i]   = w_pat.active[i] && (w_pat.bytes[i] == ANY_BYTE);
        end
        w_pat.start = close_stars(POS_W'(1), w_pat.star);
    end

    assign o_pat = w_pat;

endmodule

// File: design/gpm_auto.sv
// One step of the position-set automaton for a single path byte.
module gpm_auto import gpm_pkg::*; (
    input  t_pos  i_set,
    input  t_byte i_char,
    input  t_pat  i_pat,
    output t_pos  o_set
);

    t_pos w_nxt;

    always_comb begin
        w_nxt = '0;
        for (int i = 0; i < PATTERN_MAX; i++) begin
            if (i_set[i] && i_pat.star[i]) begin
                w_nxt[i] = 1'b1;
            end
            if (i_set[i] && i_pat.active[i] && !i_pat.star[i] &&
                (i_pat.wild[i] || (i_pat.bytes[i] == i_char))) begin
                w_nxt[i+1] = 1'b1;
            end
        end
    end

    assign o_set = close_stars(w_nxt, i_pat.star);

endmodule

// File: design/glob_path_or_name_matcher_top.sv
// The result register loads when the input register consumes the last path byte, which
// waits while an earlier result is not yet taken; the result transaction follows from it.
// Throughput: one path byte per cycle unless a held result stalls it; the position-set
// update of both automata is combinational from the input register to the result register.
// Reset (synchronous, active low) clears the pattern registers, the in-path flag
// and both valid flags, so the block starts with an empty pattern and no path open.
`include "glob_path_or_name_matcher_top_defines.svh"

module glob_path_or_name_matcher_top import gpm_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    gpm_cfg_if.sink       i_cfg,
    gpm_item_if.sink      i_item,
    gpm_result_if.source  o_result
);

    t_pat  w_pat;
    logic  r_in_valid;
    t_byte r_in_char;
    logic  r_in_last;
    logic  r_in_empty;
    logic  r_inside;
    t_pos  r_path;
    t_pos  r_name;
    logic  r_out_valid;
    logic  r_out_pm;
    logic  r_out_nm;
    logic  r_out_any;

    t_pos  w_base_path;
    t_pos  w_base_name;
    t_pos  w_adv_path;
    t_pos  w_adv_name;
    t_pos  w_new_name;
    logic  w_sep;
    logic  w_res_item;
    logic  w_out_free;
    logic  w_consume;
    logic  w_accept;
    logic  w_pm;
    logic  w_nm;

    gpm_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_pat   (w_pat)
    );

    assign w_base_path = r_inside ? r_path : w_pat.start;
    assign w_base_name = r_inside ? r_name : w_pat.start;

    gpm_auto u_auto_path (
        .i_set  (w_base_path),
        .i_char (r_in_char),
        .i_pat  (w_pat),
        .o_set  (w_adv_path)
    );

    gpm_auto u_auto_name (
        .i_set  (w_base_name),
        .i_char (r_in_char),
        .i_pat  (w_pat),
        .o_set  (w_adv_name)
    );

    assign w_sep      = (r_in_char == SLASH_BYTE) || (r_in_char == BACKSLASH_BYTE);
    assign w_new_name = w_sep ? w_pat.start : w_adv_name;
    assign w_pm       = r_in_empty ? w_pat.start[w_pat.len] : w_adv_path[w_pat.len];
    assign w_nm       = r_in_empty ? w_pat.start[w_pat.len] : w_new_name[w_pat.len];

    assign w_res_item  = r_in_empty || r_in_last;
    assign w_out_free  = !r_out_valid || o_result.ready;
    assign w_consume   = r_in_valid && (!w_res_item || w_out_free);
    assign i_item.ready = !r_in_valid || w_consume;
    assign w_accept    = i_item.valid && i_item.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_inside    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_item.ready) begin
                r_in_valid <= i_item.valid;
            end
            if (w_consume) begin
                r_inside <= !w_res_item;
            end
            if (w_consume && w_res_item) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_char  <= i_item.char_code;
            r_in_last  <= i_item.last_char;
            r_in_empty <= i_item.empty_string;
        end
        if (w_consume && !r_in_empty) begin
            r_path <= w_adv_path;
            r_name <= w_new_name;
        end
        if (w_consume && w_res_item) begin
            r_out_pm  <= w_pm;
            r_out_nm  <= w_nm;
            r_out_any <= w_pm || w_nm;
        end
    end

    assign o_result.valid      = r_out_valid;
    assign o_result.path_match = r_out_pm;
    assign o_result.name_match = r_out_nm;
    assign o_result.any_match  = r_out_any;

    `GPM_ASSERT_IMP(a_any_is_or, r_out_valid, r_out_any == (r_out_pm || r_out_nm), "any_match is not the OR of both matches")
    `GPM_ASSERT_NXT(a_end_closes_path, w_consume && w_res_item, !r_inside && r_out_valid, "path end did not close the path and post a result")
    `GPM_ASSERT_NXT(a_byte_opens_path, w_consume && !w_res_item, r_inside, "path byte did not leave the path open")
    `GPM_ASSERT_IMP(a_stall_needs_item, !i_item.ready, r_in_valid && r_out_valid && !o_result.ready, "input stalled without a blocked result")

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench of the glob path or name matcher with its own matching predictor.
module tb_top;
    import gpm_pkg::*;

    typedef struct packed {
        logic path_m;
        logic name_m;
        logic any_m;
    } t_verdict;

    typedef enum int {
        RX_ALWAYS,
        RX_LIGHT,
        RX_HEAVY
    } t_rx_mode;

    logic i_clk = 1'b0;
    logic i_rst_n;

    gpm_cfg_if    cfg_bus ();
    gpm_item_if   char_bus ();
    gpm_result_if verdict_bus ();

    glob_path_or_name_matcher_top u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg_bus),
        .i_item   (char_bus),
        .o_result (verdict_bus)
    );

    // Pattern registers and automaton state as the predictor sees them.
    logic [CFG_DATA_W-1:0] glob_head    = '0;
    logic [CFG_DATA_W-1:0] glob_tail    = '0;
    logic [PLEN_W-1:0]     glob_len_reg = '0;
    t_pos                  path_set     = '0;
    t_pos                  name_set     = '0;
    logic                  in_path      = 1'b0;

    t_verdict verdict_q[$];
    t_verdict seen_verdict;
    t_verdict due_verdict;
    int       fail_count = 0;

    t_byte    path_buf[$];
    bit       tx_gaps       = 1'b1;
    int       tx_burst_left = 0;
    int       items_sent    = 0;
    t_rx_mode rx_mode       = RX_LIGHT;
    bit       rx_hold_req   = 1'b0;
    int       rx_hold_left  = 0;

    always #1 i_clk = ~i_clk;

    function automatic int glob_size();
        return (glob_len_reg > PATTERN_MAX) ? PATTERN_MAX : int'(glob_len_reg);
    endfunction

    function automatic t_byte glob_char(int idx);
        if (idx < 8) begin
            return glob_head[8*idx +: 8];
        end
        return glob_tail[8*(idx-8) +: 8];
    endfunction

    // A star at a reached position also reaches the position after it.
    function automatic t_pos over_stars(t_pos set);
        int n;
        n = glob_size();
        for (int i = 0; i < n; i++) begin
            if (set[i] && glob_char(i) == STAR_BYTE) begin
                set[i+1] = 1'b1;
            end
        end
        return set;
    endfunction

    function automatic t_pos shift_set(t_pos set, t_byte c);
        t_pos  nxt;
        t_byte p;
        int    n;
        nxt = '0;
        n = glob_size();
        for (int i = 0; i < n; i++) begin
            if (set[i]) begin
                p = glob_char(i);
                if (p == STAR_BYTE) begin
                    nxt[i] = 1'b1;
                end else if (p == ANY_BYTE || p == c) begin
                    nxt[i+1] = 1'b1;
                end
            end
        end
        return over_stars(nxt);
    endfunction

    function automatic logic accepted(t_pos set);
        return set[glob_size()];
    endfunction

    task automatic predict_char(input t_byte c, input logic last, input logic empty);
        t_pos     origin;
        t_verdict v;
        origin = over_stars(t_pos'(1));
        if (empty) begin
            in_path  = 1'b0;
            path_set = '0;
            name_set = '0;
            v.path_m = accepted(origin);
            v.name_m = v.path_m;
        end else begin
            if (!in_path) begin
                path_set = origin;
                name_set = origin;
            end
            path_set = shift_set(path_set, c);
            if (c == SLASH_BYTE || c == BACKSLASH_BYTE) begin
                name_set = origin;
            end else begin
                name_set = shift_set(name_set, c);
            end
            in_path  = !last;
            v.path_m = accepted(path_set);
            v.name_m = accepted(name_set);
        end
        v.any_m = v.path_m | v.name_m;
        if (empty || last) begin
            verdict_q = {verdict_q, v};
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (verdict_bus.valid && verdict_bus.ready) begin
                seen_verdict = {verdict_bus.path_match, verdict_bus.name_match,
                                verdict_bus.any_match};
                if (verdict_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("unexpected result: path=%0b name=%0b any=%0b",
                                 seen_verdict.path_m, seen_verdict.name_m, seen_verdict.any_m);
                    end
                end else begin
                    due_verdict = verdict_q.pop_front();
                    if (seen_verdict !== due_verdict) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("mismatch: expected %0b%0b%0b, got %0b%0b%0b",
                                     due_verdict.path_m, due_verdict.name_m, due_verdict.any_m,
                                     seen_verdict.path_m, seen_verdict.name_m,
                                     seen_verdict.any_m);
                        end
                    end
                end
            end
            if (cfg_bus.valid && cfg_bus.ready) begin
                case (cfg_bus.index)
                    REG_PATTERN_HEAD: begin
                        glob_head = cfg_bus.data;
                    end
                    REG_PATTERN_TAIL: begin
                        glob_tail = cfg_bus.data;
                    end
                    REG_PATTERN_LENGTH: begin
                        glob_len_reg = cfg_bus.data[PLEN_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (char_bus.valid && char_bus.ready) begin
                predict_char(char_bus.char_code, char_bus.last_char, char_bus.empty_string);
            end
        end
    end

    // Result receiver: stalls according to its mode, or holds off entirely on request.
    initial begin
        verdict_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req) begin
                rx_hold_req  = 1'b0;
                rx_hold_left = 120;
            end
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                verdict_bus.ready <= 1'b0;
            end else begin
                case (rx_mode)
                    RX_ALWAYS: begin
                        verdict_bus.ready <= 1'b1;
                    end
                    RX_LIGHT: begin
                        verdict_bus.ready <= ($urandom_range(0, 3) != 0);
                    end
                    default: begin
                        verdict_bus.ready <= ($urandom_range(0, 2) == 0);
                    end
                endcase
            end
        end
    end

    task automatic send_char(input t_byte c, input logic last, input logic empty);
        int idle;
        if (tx_burst_left == 0) begin
            tx_burst_left = $urandom_range(1, 20);
            idle = tx_gaps ? $urandom_range(0, 5) : 0;
            if (idle > 0) begin
                @(negedge i_clk);
                char_bus.valid <= 1'b0;
                repeat (idle - 1) @(negedge i_clk);
            end
        end
        tx_burst_left--;
        @(negedge i_clk);
        char_bus.valid        <= 1'b1;
        char_bus.char_code    <= c;
        char_bus.last_char    <= last;
        char_bus.empty_string <= empty;
        do begin
            @(posedge i_clk);
        end while (!char_bus.ready);
        items_sent++;
    endtask

    task automatic send_text(input string s, input logic closes);
        for (int i = 0; i < s.len(); i++) begin
            send_char(t_byte'(s[i]), closes && (i == s.len() - 1), 1'b0);
        end
    endtask

    // Waits until every expected result is in and the pipeline has emptied.
    task automatic settle();
        @(negedge i_clk);
        char_bus.valid <= 1'b0;
        while (verdict_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        do begin
            @(posedge i_clk);
        end while (!cfg_bus.ready);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic load_pattern(input logic [CFG_DATA_W-1:0] head,
                                input logic [CFG_DATA_W-1:0] tail,
                                input logic [PLEN_W-1:0] len);
        settle();
        write_reg(REG_PATTERN_HEAD, head);
        write_reg(REG_PATTERN_TAIL, tail);
        write_reg(REG_PATTERN_LENGTH, CFG_DATA_W'(len));
    endtask

    function automatic logic [CFG_DATA_W-1:0] text_word(string s);
        logic [CFG_DATA_W-1:0] w;
        w = '0;
        for (int i = 0; i < s.len() && i < 8; i++) begin
            w[8*i +: 8] = s[i];
        end
        return w;
    endfunction

    function automatic t_byte pattern_pick();
        case ($urandom_range(0, 7))
            0: return STAR_BYTE;
            1: return ANY_BYTE;
            2: return "a";
            3: return "b";
            4: return ".";
            5: return SLASH_BYTE;
            6: return "c";
            default: return t_byte'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic t_byte filler_pick();
        case ($urandom_range(0, 7))
            0: return "a";
            1: return "b";
            2: return ".";
            3: return SLASH_BYTE;
            4: return BACKSLASH_BYTE;
            5: return STAR_BYTE;
            6: return ANY_BYTE;
            default: return t_byte'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic add_byte(input t_byte b);
        path_buf = {path_buf, b};
    endtask

    // Most paths are shaped after the current pattern so that matches are common.
    task automatic build_path();
        int kind;
        path_buf.delete();
        kind = $urandom_range(0, 9);
        if (kind <= 5) begin
            if ($urandom_range(0, 1) == 1) begin
                repeat ($urandom_range(1, 3)) add_byte(filler_pick());
                add_byte(($urandom_range(0, 1) == 1) ? SLASH_BYTE : BACKSLASH_BYTE);
            end
            for (int i = 0; i < glob_size(); i++) begin
                if (glob_char(i) == STAR_BYTE) begin
                    repeat ($urandom_range(0, 3)) add_byte(filler_pick());
                end else if (glob_char(i) == ANY_BYTE) begin
                    add_byte(t_byte'($urandom_range(0, 255)));
                end else begin
                    add_byte(glob_char(i));
                end
            end
            if (path_buf.size() > 0 && $urandom_range(0, 4) == 0) begin
                path_buf[$urandom_range(0, path_buf.size() - 1)] = filler_pick();
            end
        end else if (kind <= 7) begin
            repeat ($urandom_range(1, 12)) add_byte(filler_pick());
        end else if (kind == 8) begin
            repeat ($urandom_range(1, 6)) add_byte(t_byte'($urandom_range(0, 255)));
        end
    endtask

    task automatic send_path();
        if (path_buf.size() == 0) begin
            send_char(t_byte'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
        end else begin
            foreach (path_buf[i]) begin
                if (i > 0 && $urandom_range(0, 39) == 0) begin
                    send_char(t_byte'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
                end
                send_char(path_buf[i], i == path_buf.size() - 1, 1'b0);
            end
        end
    endtask

    task automatic test_empty_pattern();
        send_char(8'hFF, 1'b0, 1'b1);
        send_char(8'h00, 1'b1, 1'b0);
        send_char(SLASH_BYTE, 1'b1, 1'b0);
    endtask

    task automatic test_wildcards();
        load_pattern(text_word("a?*"), '0, 5'd3);
        send_text("x/a", 1'b0);
        send_char(8'hFF, 1'b0, 1'b0);
        send_char("z", 1'b1, 1'b0);
        send_text("ab/", 1'b1);
        send_text("p\\ab", 1'b1);
        send_text("a*", 1'b1);
    endtask

    task automatic test_abandoned_path();
        send_text("zz", 1'b0);
        send_char(8'h5A, 1'b1, 1'b1);
    endtask

    task automatic test_oversized_length();
        load_pattern({8{STAR_BYTE}}, {8'h78, {7{STAR_BYTE}}}, 5'd31);
        send_char(8'h78, 1'b1, 1'b0);
        send_char(8'h79, 1'b1, 1'b0);
    endtask

    task automatic test_midpath_update();
        load_pattern(text_word("ab"), '0, 5'd2);
        send_char("a", 1'b0, 1'b0);
        settle();
        write_reg(REG_PATTERN_HEAD, text_word("cd"));
        send_char("d", 1'b1, 1'b0);
    endtask

    task automatic test_backpressure();
        load_pattern(text_word("*.c"), '0, 5'd3);
        tx_gaps     = 1'b0;
        rx_mode     = RX_ALWAYS;
        rx_hold_req = 1'b1;
        repeat (30) begin
            if ($urandom_range(0, 1) == 1) begin
                send_text(".c", 1'b1);
            end else begin
                send_char(filler_pick(), 1'b0, 1'b0);
                send_char(filler_pick(), 1'b1, 1'b0);
            end
        end
        settle();
    endtask

    task automatic test_random_paths();
        logic [2*CFG_DATA_W-1:0] bytes_all;
        logic [PLEN_W-1:0]       len;
        int                      phase;
        int                      phase_end;
        int                      stop_at;
        phase   = 0;
        stop_at = 430;
        while (items_sent < stop_at) begin
            for (int i = 0; i < PATTERN_MAX; i++) begin
                bytes_all[8*i +: 8] = pattern_pick();
            end
            case (phase)
                0: begin
                    bytes_all = {PATTERN_MAX{STAR_BYTE}};
                    len = 5'd16;
                end
                1: begin
                    bytes_all = {PATTERN_MAX{ANY_BYTE}};
                    len = 5'd16;
                end
                2: begin
                    len = 5'd0;
                end
                3: begin
                    bytes_all = '1;
                    len = 5'd31;
                end
                default: begin
                    len = ($urandom_range(0, 5) == 0) ? PLEN_W'($urandom_range(0, 31)) :
                                                        PLEN_W'($urandom_range(1, 8));
                end
            endcase
            load_pattern(bytes_all[CFG_DATA_W-1:0], bytes_all[2*CFG_DATA_W-1:CFG_DATA_W], len);
            tx_gaps   = ($urandom_range(0, 3) != 0);
            rx_mode   = t_rx_mode'($urandom_range(0, 2));
            phase_end = items_sent + $urandom_range(25, 45);
            while (items_sent < phase_end) begin
                build_path();
                send_path();
            end
            if ($urandom_range(0, 2) == 0) begin
                send_char(filler_pick(), 1'b0, 1'b0);
            end
            phase++;
        end
    endtask

    initial begin
        i_rst_n               = 1'b0;
        char_bus.valid        = 1'b0;
        char_bus.char_code    = '0;
        char_bus.last_char    = 1'b0;
        char_bus.empty_string = 1'b0;
        cfg_bus.valid         = 1'b0;
        cfg_bus.index         = REG_PATTERN_HEAD;
        cfg_bus.data          = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_pattern();
        test_wildcards();
        test_abandoned_path();
        test_oversized_length();
        test_midpath_update();
        test_backpressure();
        test_random_paths();

        @(negedge i_clk);
        char_bus.valid <= 1'b0;
        for (int w = 0; w < 5000 && verdict_q.size() != 0; w++) begin
            @(posedge i_clk);
        end
        repeat (10) @(posedge i_clk);
        fail_count += verdict_q.size();
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

endmodule

// File: glob_path_or_name_matcher_top.f
+incdir+design
design/gpm_pkg.sv
design/gpm_if.sv
design/gpm_cfg.sv
design/gpm_auto.sv
design/glob_path_or_name_matcher_top.sv
verif/tb_top.sv
